[rtl/core/grid_chamfer_falloff_macros.svh]
// Assertion macros for the grid chamfer falloff block.
`ifndef GRID_CHAMFER_FALLOFF_MACROS_SVH
`define GRID_CHAMFER_FALLOFF_MACROS_SVH
`ifndef SYNTHESIS
`define GCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("gcf check failed");
`define GCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("gcf check failed");
`else
`define GCF_ASSERT(lbl, prop)
`define GCF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/gcf_pkg.sv]
// Package with types, constants and helpers of the grid chamfer falloff block.
`timescale 1ns / 1ps
package gcf_pkg;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int IDX_W = 12;
  localparam int VAL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [16:0] SQRT2_Q16 = 17'd92682;

  localparam logic [6:0] WIDTH_RST = 7'd64;
  localparam logic [6:0] HEIGHT_RST = 7'd64;
  localparam logic [30:0] STEP_RST = 31'd65536;
  localparam logic signed [31:0] START_RST = 32'sd0;
  localparam logic signed [31:0] WALL_RST = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_FALL  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_STEP   = 3'd2,
    CFG_START  = 3'd3,
    CFG_WALL   = 3'd4
  } cfg_reg_t;

  localparam logic signed [1:0] FWD_DX [4] = '{-2'sd1, 2'sd0, -2'sd1, 2'sd1};
  localparam logic signed [1:0] FWD_DY [4] = '{2'sd0, -2'sd1, -2'sd1, -2'sd1};

  function automatic logic signed [1:0] nb_dx(logic [1:0] j, logic bwd);
    return bwd ? -FWD_DX[j] : FWD_DX[j];
  endfunction

  function automatic logic signed [1:0] nb_dy(logic [1:0] j, logic bwd);
    return bwd ? -FWD_DY[j] : FWD_DY[j];
  endfunction
endpackage

[rtl/core/gcf_ifs.sv]
// Channel interfaces of the grid chamfer falloff block.
`timescale 1ns / 1ps
interface gcf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] cell_index;
  logic signed [31:0] cell_value;
  modport source (output valid, cmd, cell_index, cell_value, input ready);
  modport sink (input valid, cmd, cell_index, cell_value, output ready);
endinterface

interface gcf_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic        status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

interface gcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/grid_chamfer_falloff.sv]
// Top level of the grid chamfer falloff block.
`timescale 1ns / 1ps
`include "grid_chamfer_falloff_macros.svh"
// Holds up to MAX_WIDTH x MAX_HEIGHT signed Q16.16 cells in one memory with a
// registered read. After reset a clearing pass over all MAX_WIDTH * MAX_HEIGHT
// cells zeroes the memory before the first transaction is taken. A falloff
// first sweeps the N cells in use, zeroing each cell below the wall level, and
// then runs a forward and a backward relax pass; each relax pass reads each
// cell's own value and four neighbors on the single read port. One transaction
// is in flight at a time.
module grid_chamfer_falloff #(
  parameter int MAX_WIDTH = gcf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gcf_pkg::MAX_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  gcf_req_if.sink   req,
  gcf_rsp_if.source rsp,
  gcf_cfg_if.sink   cfg
);
  import gcf_pkg::*;

  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(Cells);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int NW = $clog2(Cells + 1);
  localparam int CW = (NW > IDX_W) ? NW : IDX_W;

  typedef enum logic [7:0] {
    ST_CLR  = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_RD   = 8'b0000_0100,
    ST_FILL = 8'b0000_1000,
    ST_ZRD  = 8'b0001_0000,
    ST_ZWR  = 8'b0010_0000,
    ST_REL  = 8'b0100_0000,
    ST_RWR  = 8'b1000_0000
  } state_t;

  logic [6:0]         grid_width;
  logic [6:0]         grid_height;
  logic [30:0]        falloff_step;
  logic signed [31:0] start_level;
  logic signed [31:0] wall_level;

  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic [CW-1:0] n_cells;
  logic          in_range;

  state_t             state;
  logic [AW-1:0]      idx;
  logic [XW-1:0]      x;
  logic [YW-1:0]      y;
  logic [2:0]         k;
  logic               bwd;
  logic signed [31:0] best;
  logic               own_wall;
  logic signed [31:0] fill_val;
  logic               rsp_valid;
  logic signed [31:0] read_value;
  logic               status;

  logic [31:0]   mem [Cells];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [31:0]   mem_wd;
  logic [31:0]   rd_data;

  logic               accept;
  logic [1:0]         rd_j;
  logic [1:0]         pr_j;
  logic [AW-1:0]      nb_addr;
  logic               nb_ok;
  logic signed [31:0] cand;
  logic               last_fwd;
  logic               last_bwd;
  logic [AW-1:0]      last_idx;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= WIDTH_RST;
      grid_height <= HEIGHT_RST;
      falloff_step <= STEP_RST;
      start_level <= START_RST;
      wall_level <= WALL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WIDTH:  grid_width <= cfg.data[6:0];
        CFG_HEIGHT: grid_height <= cfg.data[6:0];
        CFG_STEP:   falloff_step <= cfg.data[30:0];
        CFG_START:  start_level <= cfg.data;
        CFG_WALL:   wall_level <= cfg.data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (grid_width == 7'd0) begin
      eff_w = XW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = XW'(grid_width);
    end
    if (grid_height == 7'd0) begin
      eff_h = YW'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = YW'(MAX_HEIGHT);
    end else begin
      eff_h = YW'(grid_height);
    end
    n_cells = CW'(eff_w) * CW'(eff_h);
    in_range = CW'(req.cell_index) < n_cells;
    last_idx = AW'(n_cells - CW'(1));
  end

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE) && !rsp_valid;

  // Neighbor j is read at step j + 1 and folded in at step j + 2.
  assign rd_j = 2'(k - 3'd1);
  assign pr_j = 2'(k - 3'd2);

  always_comb begin
    logic signed [1:0]  adx;
    logic signed [1:0]  ady;
    logic signed [1:0]  pdx;
    logic signed [1:0]  pdy;
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic [AW-1:0] row_off;
    adx = nb_dx(rd_j, bwd);
    ady = nb_dy(rd_j, bwd);
    pdx = nb_dx(pr_j, bwd);
    pdy = nb_dy(pr_j, bwd);
    if (ady > 2'sd0) begin
      row_off = AW'(eff_w);
    end else if (ady < 2'sd0) begin
      row_off = -AW'(eff_w);
    end else begin
      row_off = '0;
    end
    nb_addr = idx + AW'(adx) + row_off;
    nx = $signed({2'b00, x}) + (XW+2)'(pdx);
    ny = $signed({2'b00, y}) + (YW+2)'(pdy);
    nb_ok = (nx >= 0) && (nx < $signed({2'b00, eff_w}))
         && (ny >= 0) && (ny < $signed({2'b00, eff_h}));
  end

  gcf_cand u_cand (
    .clk          (clk),
    .falloff_step (falloff_step),
    .start_level  (start_level),
    .nb_value     (rd_data),
    .diag_sel     (pr_j[1]),
    .cand         (cand)
  );

  assign last_fwd = (x == XW'(eff_w - XW'(1))) && (y == YW'(eff_h - YW'(1)));
  assign last_bwd = (x == '0) && (y == '0);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_ra = idx;
    mem_wd = fill_val;
    unique case (state)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      ST_IDLE: begin
        mem_ra = AW'(req.cell_index);
        mem_wa = AW'(req.cell_index);
        mem_wd = req.cell_value;
        mem_we = accept && (req.cmd == CMD_WRITE) && in_range;
      end
      ST_FILL: mem_we = 1'b1;
      ST_ZWR: begin
        mem_we = $signed(rd_data) < wall_level;
        mem_wd = '0;
      end
      ST_REL: mem_ra = (k == 3'd0) ? idx : nb_addr;
      ST_RWR: begin
        mem_we = 1'b1;
        mem_wd = best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      idx <= '0;
      rsp_valid <= 1'b0;
      x <= '0;
      y <= '0;
      k <= '0;
      bwd <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(Cells - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            read_value <= '0;
            status <= 1'b0;
            fill_val <= req.cell_value;
            idx <= '0;
            unique case (req.cmd)
              CMD_WRITE: begin
                status <= !in_range;
                rsp_valid <= 1'b1;
              end
              CMD_READ: begin
                if (in_range) begin
                  state <= ST_RD;
                end else begin
                  status <= 1'b1;
                  rsp_valid <= 1'b1;
                end
              end
              CMD_FILL: state <= ST_FILL;
              CMD_FALL: state <= ST_ZRD;
              default:  ;
            endcase
          end
        end
        ST_RD: begin
          read_value <= rd_data;
          rsp_valid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_FILL: begin
          idx <= idx + AW'(1);
          if (idx == last_idx) begin
            rsp_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_ZRD: state <= ST_ZWR;
        ST_ZWR: begin
          if (idx == last_idx) begin
            idx <= '0;
            x <= '0;
            y <= '0;
            k <= '0;
            bwd <= 1'b0;
            state <= ST_REL;
          end else begin
            idx <= idx + AW'(1);
            state <= ST_ZRD;
          end
        end
        ST_REL: begin
          if (k == 3'd1) begin
            best <= rd_data;
            own_wall <= $signed(rd_data) >= wall_level;
          end else if (k != 3'd0 && !own_wall && nb_ok && cand > best) begin
            best <= cand;
          end
          if (k == 3'd5) begin
            state <= ST_RWR;
          end
          k <= k + 3'd1;
        end
        ST_RWR: begin
          k <= '0;
          state <= ST_REL;
          if (!bwd) begin
            if (last_fwd) begin
              bwd <= 1'b1;
              x <= XW'(eff_w - XW'(1));
              y <= YW'(eff_h - YW'(1));
              idx <= last_idx;
            end else begin
              idx <= idx + AW'(1);
              if (x == XW'(eff_w - XW'(1))) begin
                x <= '0;
                y <= y + YW'(1);
              end else begin
                x <= x + XW'(1);
              end
            end
          end else begin
            if (last_bwd) begin
              rsp_valid <= 1'b1;
              state <= ST_IDLE;
            end else begin
              idx <= idx - AW'(1);
              if (x == '0) begin
                x <= XW'(eff_w - XW'(1));
                y <= y - YW'(1);
              end else begin
                x <= x - XW'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.read_value = read_value;
  assign rsp.status = status;

  `GCF_ASSERT(a_one_in_flight, accept |=> !req.ready)
  `GCF_ASSERT(a_rwr_after_rel, (state == ST_RWR) |-> ($past(state) == ST_REL && $past(k) == 3'd5))
  `GCF_ASSERT(a_k_bound, (state == ST_REL) |-> (k <= 3'd5))
  `GCF_ASSERT_ALWAYS(a_no_rsp_in_clear, (state == ST_CLR) |-> !rsp_valid)
endmodule

[rtl/core/gcf_cand.sv]
// Neighbor candidate: clamp to the start level, subtract the straight or diagonal step, saturate.
`timescale 1ns / 1ps
module gcf_cand (
  input  logic               clk,
  input  logic [30:0]        falloff_step,
  input  logic signed [31:0] start_level,
  input  logic signed [31:0] nb_value,
  input  logic               diag_sel,
  output logic signed [31:0] cand
);
  import gcf_pkg::*;

  logic [31:0]        diag;
  logic [47:0]        prod;
  logic signed [31:0] clamp;
  logic [31:0]        step_sel;
  logic signed [33:0] diff;

  assign prod = 48'(falloff_step) * 48'(SQRT2_Q16) + 48'd32768;

  always_ff @(posedge clk) begin
    diag <= prod[47:16];
  end

  always_comb begin
    clamp = (nb_value > start_level) ? start_level : nb_value;
    step_sel = diag_sel ? diag : {1'b0, falloff_step};
    diff = 34'(clamp) - $signed({2'b00, step_sel});
    if (diff < -34'sd2147483648) begin
      cand = 32'sh8000_0000;
    end else begin
      cand = diff[31:0];
    end
  end
endmodule
